>>> rtl/sc2a_pkg.sv
// Shared types, constants and key tables for the scan code to ASCII queue.
`default_nettype none
package sc2a_pkg;

	localparam int QUEUE_DEPTH_DEF = 256;

	localparam int CHAR_W = 7;
	localparam int SCAN_W = 8;
	localparam int TDATA_IN_W = 8;
	localparam int TDATA_OUT_W = 16;

	localparam logic [6:0] SC_LSHIFT = 7'h2A;
	localparam logic [6:0] SC_RSHIFT = 7'h36;
	localparam logic [6:0] SC_CAPS = 7'h3A;

	// Item kinds carried on the input tuser bit.
	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic              push;
		logic [CHAR_W-1:0] ch;
	} push_req_t;

	typedef struct packed {
		logic              dropped;
		logic              was_empty;
		logic [CHAR_W-1:0] read_char;
	} result_t;

	function automatic logic [CHAR_W-1:0] plain_char(input logic [6:0] k);
		logic [CHAR_W-1:0] c;
		case (k)
			7'd1:  c = 7'h1B;
			7'd2:  c = 7'h31;
			7'd3:  c = 7'h32;
			7'd4:  c = 7'h33;
			7'd5:  c = 7'h34;
			7'd6:  c = 7'h35;
			7'd7:  c = 7'h36;
			7'd8:  c = 7'h37;
			7'd9:  c = 7'h38;
			7'd10: c = 7'h39;
			7'd11: c = 7'h30;
			7'd12: c = 7'h2D;
			7'd13: c = 7'h3D;
			7'd14: c = 7'h08;
			7'd15: c = 7'h09;
			7'd16: c = 7'h71;
			7'd17: c = 7'h77;
			7'd18: c = 7'h65;
			7'd19: c = 7'h72;
			7'd20: c = 7'h74;
			7'd21: c = 7'h79;
			7'd22: c = 7'h75;
			7'd23: c = 7'h69;
			7'd24: c = 7'h6F;
			7'd25: c = 7'h70;
			7'd26: c = 7'h5B;
			7'd27: c = 7'h5D;
			7'd28: c = 7'h0A;
			7'd30: c = 7'h61;
			7'd31: c = 7'h73;
			7'd32: c = 7'h64;
			7'd33: c = 7'h66;
			7'd34: c = 7'h67;
			7'd35: c = 7'h68;
			7'd36: c = 7'h6A;
			7'd37: c = 7'h6B;
			7'd38: c = 7'h6C;
			7'd39: c = 7'h3B;
			7'd40: c = 7'h27;
			7'd41: c = 7'h60;
			7'd43: c = 7'h5C;
			7'd44: c = 7'h7A;
			7'd45: c = 7'h78;
			7'd46: c = 7'h63;
			7'd47: c = 7'h76;
			7'd48: c = 7'h62;
			7'd49: c = 7'h6E;
			7'd50: c = 7'h6D;
			7'd51: c = 7'h2C;
			7'd52: c = 7'h2E;
			7'd53: c = 7'h2F;
			7'd55: c = 7'h2A;
			7'd57: c = 7'h20;
			7'd71: c = 7'h37;
			7'd72: c = 7'h38;
			7'd73: c = 7'h39;
			7'd74: c = 7'h2D;
			7'd75: c = 7'h34;
			7'd76: c = 7'h35;
			7'd77: c = 7'h36;
			7'd78: c = 7'h2B;
			7'd79: c = 7'h31;
			7'd80: c = 7'h32;
			7'd81: c = 7'h33;
			7'd82: c = 7'h30;
			7'd83: c = 7'h2E;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] shifted_char(input logic [6:0] k);
		logic [CHAR_W-1:0] c;
		case (k)
			7'd1:  c = 7'h1B;
			7'd2:  c = 7'h21;
			7'd3:  c = 7'h40;
			7'd4:  c = 7'h23;
			7'd5:  c = 7'h24;
			7'd6:  c = 7'h25;
			7'd7:  c = 7'h5E;
			7'd8:  c = 7'h26;
			7'd9:  c = 7'h2A;
			7'd10: c = 7'h28;
			7'd11: c = 7'h29;
			7'd12: c = 7'h5F;
			7'd13: c = 7'h2B;
			7'd14: c = 7'h08;
			7'd15: c = 7'h09;
			7'd16: c = 7'h51;
			7'd17: c = 7'h57;
			7'd18: c = 7'h45;
			7'd19: c = 7'h52;
			7'd20: c = 7'h54;
			7'd21: c = 7'h59;
			7'd22: c = 7'h55;
			7'd23: c = 7'h49;
			7'd24: c = 7'h4F;
			7'd25: c = 7'h50;
			7'd26: c = 7'h7B;
			7'd27: c = 7'h7D;
			7'd28: c = 7'h0A;
			7'd30: c = 7'h41;
			7'd31: c = 7'h53;
			7'd32: c = 7'h44;
			7'd33: c = 7'h46;
			7'd34: c = 7'h47;
			7'd35: c = 7'h48;
			7'd36: c = 7'h4A;
			7'd37: c = 7'h4B;
			7'd38: c = 7'h4C;
			7'd39: c = 7'h3A;
			7'd40: c = 7'h22;
			7'd41: c = 7'h7E;
			7'd43: c = 7'h7C;
			7'd44: c = 7'h5A;
			7'd45: c = 7'h58;
			7'd46: c = 7'h43;
			7'd47: c = 7'h56;
			7'd48: c = 7'h42;
			7'd49: c = 7'h4E;
			7'd50: c = 7'h4D;
			7'd51: c = 7'h3C;
			7'd52: c = 7'h3E;
			7'd53: c = 7'h3F;
			7'd55: c = 7'h2A;
			7'd57: c = 7'h20;
			7'd71: c = 7'h37;
			7'd72: c = 7'h38;
			7'd73: c = 7'h39;
			7'd74: c = 7'h2D;
			7'd75: c = 7'h34;
			7'd76: c = 7'h35;
			7'd77: c = 7'h36;
			7'd78: c = 7'h2B;
			7'd79: c = 7'h31;
			7'd80: c = 7'h32;
			7'd81: c = 7'h33;
			7'd82: c = 7'h30;
			7'd83: c = 7'h2E;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

>>> rtl/sc2a_decode.sv
// Keyboard modifier state and scan code to character translation.
`default_nettype none
module sc2a_decode (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       take,
	input  wire logic                       op,
	input  wire logic [sc2a_pkg::SCAN_W-1:0] scan_code,
	output sc2a_pkg::push_req_t             push_req
);
	import sc2a_pkg::*;

	logic              shift_q;
	logic              caps_q;
	logic              rel;
	logic [6:0]        key;
	logic              is_shift;
	logic              is_caps;
	logic [CHAR_W-1:0] base_ch;
	logic [CHAR_W-1:0] ch;

	assign rel = scan_code[7];
	assign key = scan_code[6:0];
	assign is_shift = (key == SC_LSHIFT) || (key == SC_RSHIFT);
	assign is_caps = (key == SC_CAPS);

	always_comb begin
		base_ch = shift_q ? shifted_char(key) : plain_char(key);
		ch = base_ch;
		// Caps Lock swaps the case of letters only; flipping bit 5 moves 32.
		if (caps_q && ((base_ch inside {[7'h61:7'h7A]}) || (base_ch inside {[7'h41:7'h5A]}))) begin
			ch = base_ch ^ 7'h20;
		end
	end

	always_comb begin
		push_req.ch = ch;
		push_req.push = take && (op == OP_SCAN) && !rel && !is_shift && !is_caps
			&& (ch != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			caps_q <= 1'b0;
		end else if (take && (op == OP_SCAN)) begin
			if (rel) begin
				if (is_shift) begin
					shift_q <= 1'b0;
				end
			end else if (is_shift) begin
				shift_q <= 1'b1;
			end else if (is_caps) begin
				caps_q <= !caps_q;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/sc2a_queue.sv
// Character ring queue in a synchronous memory, with its result stage.
`default_nettype none
module sc2a_queue #(
	parameter int QUEUE_DEPTH = sc2a_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic                op,
	input  wire sc2a_pkg::push_req_t push_req,
	input  wire logic                adv_s1,
	output logic                     valid_s1,
	output sc2a_pkg::result_t        result_s1
);
	import sc2a_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

	logic [CHAR_W-1:0] mem [QUEUE_DEPTH];

	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW-1:0]     wr_next;
	logic [PW-1:0]     rd_next;
	logic              is_empty;
	logic              is_full;
	logic              do_pop;
	logic              do_push;
	logic [CHAR_W-1:0] rdata_s1;
	logic              hit_s1;
	logic              empty_s1;
	logic              drop_s1;

	assign wr_next = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
	assign is_empty = (wr_ptr_q == rd_ptr_q);
	assign is_full = (wr_next == rd_ptr_q);
	assign do_pop = take && (op == OP_READ) && !is_empty;
	assign do_push = push_req.push && !is_full;

	// A pushed entry is written at this edge and can only be popped from the
	// next cycle on, so the registered read never sees a stale entry.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_req.ch;
		end
		if (do_pop) begin
			rdata_s1 <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_next;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_next;
			end
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hit_s1 <= do_pop;
			empty_s1 <= (op == OP_READ) && is_empty;
			drop_s1 <= push_req.push && is_full;
		end
	end

	always_comb begin
		result_s1.read_char = hit_s1 ? rdata_s1 : '0;
		result_s1.was_empty = empty_s1;
		result_s1.dropped = drop_s1;
	end

endmodule
`default_nettype wire

>>> rtl/scancode_to_ascii_fifo.sv
// Top level of the set-1 scan code to ASCII keyboard character queue.
`default_nettype none
// Each input transfer is either a raw set-1 scan byte (tuser low) or a request to
// read one character (tuser high), and each gives exactly one output transfer.
// Scan bytes update the Shift and Caps Lock state and translate other key presses
// to US-layout ASCII; a nonzero character is stored in a ring queue of
// QUEUE_DEPTH entries that holds at most QUEUE_DEPTH-1 characters. A character
// that finds the queue full is discarded and its result carries dropped. A read
// returns the oldest character, or zero with was_empty when the queue is empty.
// The block takes one transfer per clock cycle while the output is not stalled, and
// each result passes through the registered read of the queue memory and then the
// output register. Input tready stays high while the result stage is empty or can
// move on, so a result waiting at the output does not stop the next transfer. The
// queue memory needs no clearing after reset; only entries already written are
// ever read.
module scancode_to_ascii_fifo #(
	parameter int QUEUE_DEPTH = sc2a_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// tdata: scan_code [7:0]
	input  wire logic [sc2a_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
	// tuser: op [0] (low for a scan byte, high for a read request)
	input  wire logic                             s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// tdata: read_char [6:0], was_empty [7], dropped [8], zero [15:9]
	output logic [sc2a_pkg::TDATA_OUT_W-1:0]      m_axis_tdata
);
	import sc2a_pkg::*;

	logic      take;
	logic      adv_s1;
	logic      valid_s1;
	push_req_t push_req;
	result_t   result_s1;
	logic      out_valid_q;
	result_t   out_data_q;

	// The result stage advances when the output register is free or drains.
	assign adv_s1 = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign take = s_axis_tvalid && s_axis_tready;

	sc2a_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.op        (s_axis_tuser),
		.scan_code (s_axis_tdata[SCAN_W-1:0]),
		.push_req  (push_req)
	);

	sc2a_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.op        (s_axis_tuser),
		.push_req  (push_req),
		.adv_s1    (adv_s1),
		.valid_s1  (valid_s1),
		.result_s1 (result_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= result_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = TDATA_OUT_W'(out_data_q);

endmodule
`default_nettype wire
